// ===== hdl/sgb5_pkg.sv =====
`default_nettype none
package sgb5_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int COEF_BITS  = 16;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int FW_W   = COL_W + 1;
    localparam int DIM_W  = 11;
    localparam int SW     = (FW_W > DIM_W ? FW_W : DIM_W) + 2;
    localparam int COEF_W = 16;
    localparam int SUM_W  = COEF_W + 11;
    localparam int RAM_W  = 32;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    localparam int Q_DEPTH = 16;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = Q_PTR_W + 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 3'd0;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 3'd1;
    localparam t_cfg_idx CFG_COEF_OUTER   = 3'd2;
    localparam t_cfg_idx CFG_COEF_INNER   = 3'd3;
    localparam t_cfg_idx CFG_COEF_CENTER  = 3'd4;

    localparam logic signed [SW-1:0] S_ZERO = SW'(0);
    localparam logic signed [SW-1:0] S_ONE  = SW'(1);
    localparam logic signed [SW-1:0] S_TWO  = SW'(2);
    localparam logic signed [SW-1:0] S_FOUR = SW'(4);
    localparam logic signed [SW-1:0] S_FIVE = SW'(5);

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_MID,
        EMIT_WRAP0,
        EMIT_WRAP1
    } t_emit;

    typedef struct packed {
        logic [7:0] pixel_in;
        logic       drain;
    } t_in_word;

    typedef struct packed {
        logic [7:0] pixel_out;
        logic       frame_end;
    } t_out_word;

    typedef struct packed {
        logic [7:0]       pix;
        logic [COL_W-1:0] col;
        logic [DIM_W-1:0] row;
        logic [FW_W-1:0]  w;
        logic [DIM_W-1:0] h;
        logic             do_vert;
        logic             do_write;
        t_emit            emit;
        logic             last;
    } t_item;

    typedef struct packed {
        logic [COEF_W-1:0] outer;
        logic [COEF_W-1:0] inner;
        logic [COEF_W-1:0] center;
    } t_coefs;

    // reflect addressing about the edges of a line of n
    function automatic logic signed [SW-1:0] f_mirror(input logic signed [SW-1:0] v,
                                                     input logic signed [SW-1:0] n);
        logic signed [SW-1:0] m;
        if (v < S_ZERO) begin
            m = -v - S_ONE;
        end else if (v >= n) begin
            m = (n <<< 1) - v - S_ONE;
        end else begin
            m = v;
        end
        return m;
    endfunction

    // window slot holding column col, window entry 0 holds column base
    function automatic logic [2:0] f_win_idx(input logic signed [SW-1:0] col,
                                             input logic signed [SW-1:0] base,
                                             input logic signed [SW-1:0] n);
        logic signed [SW-1:0] i;
        i = f_mirror(col, n) - base;
        if (i < S_ZERO) begin
            i = S_ZERO;
        end
        if (i > S_FOUR) begin
            i = S_FOUR;
        end
        return i[2:0];
    endfunction

endpackage
`default_nettype wire

// ===== hdl/sgb5_ram.sv =====
`default_nettype none
module sgb5_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/sgb5_taps.sv =====
`default_nettype none
module sgb5_taps import sgb5_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic [4:0][7:0] i_taps,
    input  wire t_coefs          i_coefs,
    output logic      [7:0]      o_pix
);

    logic [COEF_W+8:0] r_po;
    logic [COEF_W+8:0] r_pi;
    logic [COEF_W+7:0] r_pc;
    logic [8:0]        n_sum_outer;
    logic [8:0]        n_sum_inner;
    logic [SUM_W-1:0]  n_sum;
    logic [SUM_W-1:0]  n_shr;

    assign n_sum_outer = {1'b0, i_taps[0]} + {1'b0, i_taps[4]};
    assign n_sum_inner = {1'b0, i_taps[1]} + {1'b0, i_taps[3]};

    // products, then sum with truncation and saturation
    always_ff @(posedge i_clk) begin
        r_po <= i_coefs.outer * n_sum_outer;
        r_pi <= i_coefs.inner * n_sum_inner;
        r_pc <= i_coefs.center * i_taps[2];
    end

    assign n_sum = SUM_W'(r_po) + SUM_W'(r_pi) + SUM_W'(r_pc);
    assign n_shr = n_sum >> COEF_BITS;

    always_ff @(posedge i_clk) begin
        o_pix <= (n_shr > SUM_W'(255)) ? 8'hff : n_shr[7:0];
    end

endmodule
`default_nettype wire

// ===== hdl/sgb5_vpass.sv =====
`default_nettype none
module sgb5_vpass import sgb5_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    input  wire t_item  i_item,
    input  wire t_coefs i_coefs,
    output logic        o_valid,
    output t_item       o_item,
    output logic [7:0]  o_vert
);

    logic             r_s1_valid, r_s2_valid, r_s3_valid;
    t_item            r_s1, r_s2, r_s3;
    logic             r_fwd_hit;
    logic [RAM_W-1:0] r_fwd_data;
    logic [RAM_W-1:0] ram_rdata;
    logic [RAM_W-1:0] n_rd;
    logic [RAM_W-1:0] n_wdata;
    logic             n_we;
    logic [4:0][7:0]  n_taps;
    logic signed [SW-1:0] n_row_s, n_h_s, n_y;
    logic signed [SW-1:0] n_v [5];
    logic signed [SW-1:0] n_m [5];

    // one word per column holds the four raw row slots
    sgb5_ram #(.WIDTH(RAM_W), .DEPTH(MAX_WIDTH)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (r_s1.col),
        .i_wdata (n_wdata),
        .i_re    (i_valid),
        .i_raddr (i_item.col),
        .o_rdata (ram_rdata)
    );

    assign n_we = r_s1_valid && r_s1.do_write;
    assign n_rd = r_fwd_hit ? r_fwd_data : ram_rdata;

    always_comb begin
        n_wdata = n_rd;
        n_wdata[8*r_s1.row[1:0] +: 8] = r_s1.pix;
    end

    assign n_row_s = $signed(SW'(r_s1.row));
    assign n_h_s   = $signed(SW'(r_s1.h));
    assign n_y     = n_row_s - S_TWO;

    always_comb begin
        for (int k = 0; k < 5; k++) begin
            n_v[k] = n_y + SW'(k) - S_TWO;
            n_m[k] = f_mirror(n_v[k], n_h_s);
            if (n_m[k] == n_row_s) begin
                n_taps[k] = r_s1.pix;
            end else begin
                n_taps[k] = n_rd[8*n_m[k][1:0] +: 8];
            end
        end
    end

    sgb5_taps u_taps (
        .i_clk   (i_clk),
        .i_taps  (n_taps),
        .i_coefs (i_coefs),
        .o_pix   (o_vert)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            // write to the column being read lands after the read
            r_fwd_hit  <= i_valid && n_we && (r_s1.col == i_item.col);
        end
        r_s1       <= i_item;
        r_s2       <= r_s1;
        r_s3       <= r_s2;
        r_fwd_data <= n_wdata;
    end

    assign o_valid = r_s3_valid;
    assign o_item  = r_s3;

endmodule
`default_nettype wire

// ===== hdl/sgb5_hpass.sv =====
`default_nettype none
module sgb5_hpass import sgb5_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_item      i_item,
    input  wire logic [7:0] i_vert,
    input  wire t_coefs     i_coefs,
    output logic            o_valid,
    output t_out_word       o_word
);

    logic [4:0][7:0] r_win, r_snap, n_win, n_src;
    logic [4:0][7:0] r_sel, n_sel;
    logic            r_h1_valid, r_h2_valid, r_h3_valid;
    logic            r_h1_last, r_h2_last, r_h3_last;
    logic [7:0]      tap_pix;
    logic signed [SW-1:0] n_c_s, n_w_s, n_x, n_base;
    logic [2:0]      n_idx [5];

    assign n_win = (i_valid && i_item.do_vert) ? {i_vert, r_win[4:1]} : r_win;
    assign n_c_s = $signed(SW'(i_item.col));
    assign n_w_s = $signed(SW'(i_item.w));

    always_comb begin
        case (i_item.emit)
            EMIT_WRAP0: begin
                n_src  = r_win;
                n_x    = n_w_s - S_TWO;
                n_base = n_w_s - S_FIVE;
            end
            EMIT_WRAP1: begin
                n_src  = r_snap;
                n_x    = n_w_s - S_ONE;
                n_base = n_w_s - S_FIVE;
            end
            default: begin
                n_src  = n_win;
                n_x    = n_c_s - S_TWO;
                n_base = n_c_s - S_FOUR;
            end
        endcase
        for (int k = 0; k < 5; k++) begin
            n_idx[k] = f_win_idx(n_x + SW'(k) - S_TWO, n_base, n_w_s);
            n_sel[k] = n_src[n_idx[k]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_h1_valid <= 1'b0;
            r_h2_valid <= 1'b0;
            r_h3_valid <= 1'b0;
        end else begin
            r_win      <= n_win;
            r_h1_valid <= i_valid && (i_item.emit != EMIT_NONE);
            r_h2_valid <= r_h1_valid;
            r_h3_valid <= r_h2_valid;
        end
        if (i_valid && i_item.emit == EMIT_WRAP0) begin
            r_snap <= r_win;
        end
        r_sel     <= n_sel;
        r_h1_last <= i_item.last;
        r_h2_last <= r_h1_last;
        r_h3_last <= r_h2_last;
    end

    sgb5_taps u_taps (
        .i_clk   (i_clk),
        .i_taps  (r_sel),
        .i_coefs (i_coefs),
        .o_pix   (tap_pix)
    );

    assign o_valid          = r_h3_valid;
    assign o_word.pixel_out = tap_pix;
    assign o_word.frame_end = r_h3_last;

endmodule
`default_nettype wire

// ===== hdl/sgb5_outq.sv =====
`default_nettype none
module sgb5_outq import sgb5_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_word i_word,
    input  wire logic      i_pop,
    output logic           o_valid,
    output t_out_word      o_word,
    output logic [Q_CNT_W-1:0] o_count
);

    t_out_word          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            r_count <= r_count + Q_CNT_W'(i_push) - Q_CNT_W'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule
`default_nettype wire

// ===== hdl/separable_gaussian_blur_5x5_unit.sv =====
`default_nettype none
// 5x5 separable gaussian blur on an 8-bit greyscale raster stream. one word
// per clock is taken and one result word per clock is given in steady state
// while the result queue has room and results are taken; the vertical pass
// reads and rewrites one 32-bit line ram word per column (four raw row slots)
// with a single read and a single write port each cycle, which sets the rate.
// results lag the input by two rows and two columns, so after the w*h pixels
// of a frame send 2*w+2 drain words; the last result carries frame_end. the
// line ram is not cleared after reset, every entry is written before it is
// read. size registers are sampled at the first pixel of a frame.
module separable_gaussian_blur_5x5_unit import sgb5_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input words
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_word             i_in_word,
    // result words
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_word                 o_out_word,
    // register writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data
);

    // configuration registers
    logic [DIM_W-1:0] r_cfg_w, r_cfg_h;
    t_coefs           r_coefs;

    // stream position and frame size latched at first pixel
    logic [DIM_W-1:0] r_row;
    logic [COL_W-1:0] r_col;
    logic [FW_W-1:0]  r_fw;
    logic [DIM_W-1:0] r_fh;

    // results in flight ahead of the output queue
    logic [Q_CNT_W-1:0] r_inflight;

    logic             in_acc, out_acc, first, ignore, item_valid, wrap_col;
    logic [FW_W-1:0]  n_w, clamp_w;
    logic [DIM_W-1:0] n_h, clamp_h;
    t_item            n_item;
    logic [DIM_W:0]   row_x, h_x;
    logic [DIM_W-1:0] n_row;
    logic [COL_W-1:0] n_col;

    logic       v_valid;
    t_item      v_item;
    logic [7:0] v_pix;
    logic       h_valid;
    t_out_word  h_word;
    logic [Q_CNT_W-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w        <= DIM_W'(640);
            r_cfg_h        <= DIM_W'(480);
            r_coefs.outer  <= COEF_W'(3572);
            r_coefs.inner  <= COEF_W'(16004);
            r_coefs.center <= COEF_W'(26385);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_cfg_w        <= i_cfg_data[DIM_W-1:0];
                CFG_IMAGE_HEIGHT: r_cfg_h        <= i_cfg_data[DIM_W-1:0];
                CFG_COEF_OUTER:   r_coefs.outer  <= i_cfg_data;
                CFG_COEF_INNER:   r_coefs.inner  <= i_cfg_data;
                CFG_COEF_CENTER:  r_coefs.center <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // accept while the queue can hold every result already in flight
    assign o_in_ready = ((Q_CNT_W+1)'(r_inflight) + (Q_CNT_W+1)'(q_count))
                        < (Q_CNT_W+1)'(Q_DEPTH);
    assign in_acc  = i_in_valid && o_in_ready;
    assign out_acc = o_out_valid && i_out_ready;

    // size clamp to the supported range
    always_comb begin
        if (r_cfg_w < DIM_W'(2)) begin
            clamp_w = FW_W'(2);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            clamp_w = FW_W'(MAX_WIDTH);
        end else begin
            clamp_w = FW_W'(r_cfg_w);
        end
        if (r_cfg_h < DIM_W'(2)) begin
            clamp_h = DIM_W'(2);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            clamp_h = DIM_W'(MAX_HEIGHT);
        end else begin
            clamp_h = r_cfg_h;
        end
    end

    assign first = (r_row == '0) && (r_col == '0);
    // drain words before a frame starts or before all pixels arrived do nothing
    assign ignore = i_in_word.drain && (first || (r_row < r_fh));
    assign item_valid = in_acc && !ignore;

    assign n_w   = first ? clamp_w : r_fw;
    assign n_h   = first ? clamp_h : r_fh;
    assign row_x = (DIM_W+1)'(r_row);
    assign h_x   = (DIM_W+1)'(n_h);

    always_comb begin
        n_item.pix      = i_in_word.pixel_in;
        n_item.col      = r_col;
        n_item.row      = r_row;
        n_item.w        = n_w;
        n_item.h        = n_h;
        n_item.do_vert  = (r_row >= DIM_W'(2)) && (row_x < h_x + (DIM_W+1)'(2));
        n_item.do_write = (r_row < n_h);
        n_item.last     = (row_x == h_x + (DIM_W+1)'(2)) && (r_col == COL_W'(1));
        if (r_col >= COL_W'(2) && r_row >= DIM_W'(2)) begin
            n_item.emit = EMIT_MID;
        end else if (r_col == '0 && r_row >= DIM_W'(3)) begin
            n_item.emit = EMIT_WRAP0;
        end else if (r_col == COL_W'(1) && r_row >= DIM_W'(3)) begin
            n_item.emit = EMIT_WRAP1;
        end else begin
            n_item.emit = EMIT_NONE;
        end
    end

    // next stream position
    assign wrap_col = (FW_W'(r_col) + FW_W'(1)) >= n_w;
    always_comb begin
        if (n_item.last) begin
            n_row = '0;
            n_col = '0;
        end else if (wrap_col) begin
            n_row = r_row + DIM_W'(1);
            n_col = '0;
        end else begin
            n_row = r_row;
            n_col = r_col + COL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_fw       <= '0;
            r_fh       <= '0;
            r_inflight <= '0;
        end else begin
            if (item_valid) begin
                r_row <= n_row;
                r_col <= n_col;
                if (first) begin
                    r_fw <= clamp_w;
                    r_fh <= clamp_h;
                end
            end
            r_inflight <= r_inflight
                        + Q_CNT_W'(item_valid && (n_item.emit != EMIT_NONE))
                        - Q_CNT_W'(h_valid);
        end
    end

    sgb5_vpass u_vpass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (item_valid),
        .i_item  (n_item),
        .i_coefs (r_coefs),
        .o_valid (v_valid),
        .o_item  (v_item),
        .o_vert  (v_pix)
    );

    sgb5_hpass u_hpass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (v_valid),
        .i_item  (v_item),
        .i_vert  (v_pix),
        .i_coefs (r_coefs),
        .o_valid (h_valid),
        .o_word  (h_word)
    );

    sgb5_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (h_valid),
        .i_word  (h_word),
        .i_pop   (out_acc),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .o_count (q_count)
    );

endmodule
`default_nettype wire

// ===== hdl/sgb5_checker.sv =====
`default_nettype none
module sgb5_checker import sgb5_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_in_ready,
    input wire logic                 o_out_valid,
    input wire logic                 i_out_ready,
    input wire t_out_word            o_out_word
);

    // reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

    // input back-pressure only comes when the results queued and in flight fill the result queue
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result word waiting");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("result word changed while stalled");

endmodule

bind separable_gaussian_blur_5x5_unit sgb5_checker u_sgb5_checker (.*);
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
    import sgb5_pkg::*;

    // clock, reset and the block's ports
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    t_in_word             in_word = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b1;
    t_out_word            out_word;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;

    separable_gaussian_blur_5x5_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // blur predictor state: raw lines, vertical-pass window, stream position
    logic [7:0]  raw_lines [4*MAX_WIDTH];
    logic [7:0]  vwin [5];
    int          pos_col, pos_row, lat_w, lat_h;
    logic [7:0]  held_pix;
    logic [10:0] reg_w, reg_h;
    logic [15:0] w_outer, w_inner, w_center;

    t_out_word   blurred_q [$];
    int          mismatches = 0;
    int          words_sent = 0;
    int          pixels_out = 0;
    int          frames_done = 0;
    int          cycle_cnt = 0;
    bit          quiet = 1'b0;

    function automatic int reflect(int n, int v);
        if (v < 0) return -v - 1;
        if (v >= n) return 2 * n - v - 1;
        return v;
    endfunction

    // weighted 5-tap sum, truncated and saturated to 8 bits
    function automatic logic [7:0] tap5(int a, int b, int m, int d, int e);
        longint unsigned s;
        s = longint'(w_outer) * (a + e) + longint'(w_inner) * (b + d)
          + longint'(w_center) * m;
        s = s >> COEF_BITS;
        return (s > 255) ? 8'd255 : s[7:0];
    endfunction

    function automatic int win_val(int col, int base);
        int i;
        i = reflect(lat_w, col) - base;
        if (i < 0) i = 0;
        if (i > 4) i = 4;
        return vwin[i];
    endfunction

    function automatic logic [7:0] hpass(int x, int base);
        return tap5(win_val(x - 2, base), win_val(x - 1, base), win_val(x, base),
                    win_val(x + 1, base), win_val(x + 2, base));
    endfunction

    function automatic int raw_val(int row, int r, int c, int p);
        if (row == r) return p;
        return raw_lines[(row & 3) * MAX_WIDTH + c];
    endfunction

    function automatic logic [7:0] vpass(int r, int c, int p);
        int y;
        y = r - 2;
        return tap5(raw_val(reflect(lat_h, y - 2), r, c, p),
                    raw_val(reflect(lat_h, y - 1), r, c, p),
                    raw_val(reflect(lat_h, y), r, c, p),
                    raw_val(reflect(lat_h, y + 1), r, c, p),
                    raw_val(reflect(lat_h, y + 2), r, c, p));
    endfunction

    // advance the predictor by one accepted word; returns 1 if the word was ignored
    function automatic bit blur_step(t_in_word wd);
        int r, c, p;
        bit emit, last;
        logic [7:0] res;
        r = pos_row;
        c = pos_col;
        p = wd.pixel_in;
        emit = 0;
        last = 0;
        res = '0;
        if (r == 0 && c == 0) begin
            if (wd.drain) return 1'b1;
            lat_w = (reg_w < 2) ? 2 : ((reg_w > MAX_WIDTH) ? MAX_WIDTH : reg_w);
            lat_h = (reg_h < 2) ? 2 : ((reg_h > MAX_HEIGHT) ? MAX_HEIGHT : reg_h);
        end else if (r < lat_h && wd.drain) begin
            return 1'b1;
        end
        // first two columns of a row emit the tail of the row above
        if (c < 2 && r >= 3) begin
            if (c == 0) begin
                res = hpass(lat_w - 2, lat_w - 5);
                held_pix = hpass(lat_w - 1, lat_w - 5);
            end else begin
                res = held_pix;
            end
            emit = 1;
            last = (r == lat_h + 2 && c == 1);
        end
        if (r >= 2 && r - 2 < lat_h) begin
            for (int i = 0; i < 4; i++) vwin[i] = vwin[i+1];
            vwin[4] = vpass(r, c, p);
        end
        if (c >= 2 && r >= 2) begin
            res = hpass(c - 2, c - 4);
            emit = 1;
        end
        if (r < lat_h) raw_lines[(r & 3) * MAX_WIDTH + c] = 8'(p);
        c++;
        if (c >= lat_w) begin
            c = 0;
            r++;
        end
        if (last) begin
            c = 0;
            r = 0;
            frames_done++;
        end
        pos_col = c;
        pos_row = r;
        if (emit) blurred_q.push_back('{pixel_out: res, frame_end: last});
        return 1'b0;
    endfunction

    function automatic void apply_reg(t_cfg_idx idx, logic [15:0] v);
        case (idx)
            CFG_IMAGE_WIDTH:  reg_w = v[10:0];
            CFG_IMAGE_HEIGHT: reg_h = v[10:0];
            CFG_COEF_OUTER:   w_outer = v;
            CFG_COEF_INNER:   w_inner = v;
            CFG_COEF_CENTER:  w_center = v;
            default: ;
        endcase
    endfunction

    // ---- result checking at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (blurred_q.size() == 0) begin
                $error("unexpected result word: pixel_out %0d frame_end %0d",
                       out_word.pixel_out, out_word.frame_end);
                mismatches++;
            end else begin
                t_out_word want;
                want = blurred_q.pop_front();
                pixels_out++;
                if (out_word.pixel_out !== want.pixel_out) begin
                    $error("pixel_out: expected %0d, actual %0d",
                           want.pixel_out, out_word.pixel_out);
                    mismatches++;
                end
                if (out_word.frame_end !== want.frame_end) begin
                    $error("frame_end: expected %0d, actual %0d",
                           want.frame_end, out_word.frame_end);
                    mismatches++;
                end
            end
        end
    end

    // ---- result-side stalls in short bursts
    always begin
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            out_ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        out_ready <= 1'b1;
    end

    // ---- watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > 3000000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---- stimulus helpers, all entered and left at a falling edge
    task automatic send_word(logic [7:0] pix, logic drn, output t_out_word got,
                             output bit had);
        int q_size;
        bit ign;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= '{pixel_in: pix, drain: drn};
        do @(posedge i_clk); while (!in_ready);
        q_size = blurred_q.size();
        ign = blur_step('{pixel_in: pix, drain: drn});
        if (!ign) words_sent++;
        had = (blurred_q.size() > q_size);
        got = had ? blurred_q[$] : '0;
        @(negedge i_clk);
    endtask

    // block idle: every result in, then the pipeline's depth once more
    task automatic settle();
        in_valid <= 1'b0;
        while (blurred_q.size() != 0) @(negedge i_clk);
        repeat (15) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        do @(posedge i_clk); while (!cfg_ready);
        apply_reg(idx, v);
        @(negedge i_clk);
    endtask

    task automatic setup_frame(logic [15:0] w, logic [15:0] h, logic [15:0] co,
                               logic [15:0] ci, logic [15:0] cc);
        settle();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_COEF_OUTER, co);
        write_reg(CFG_COEF_INNER, ci);
        write_reg(CFG_COEF_CENTER, cc);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // one frame with random content, stray drains and pixels in the drain tail
    task automatic random_frame(int noise);
        t_out_word g;
        bit h;
        int w, ht;
        w = (reg_w < 2) ? 2 : ((reg_w > MAX_WIDTH) ? MAX_WIDTH : reg_w);
        ht = (reg_h < 2) ? 2 : ((reg_h > MAX_HEIGHT) ? MAX_HEIGHT : reg_h);
        if (noise != 0 && $urandom_range(0, 3) == 0) send_word(8'($urandom), 1'b1, g, h);
        for (int i = 0; i < w * ht; i++) begin
            if (noise != 0 && $urandom_range(0, 19) == 0)
                send_word(8'($urandom), 1'b1, g, h);
            send_word(8'($urandom), 1'b0, g, h);
        end
        for (int i = 0; i < 2 * w + 2; i++)
            send_word(8'($urandom),
                      (noise != 0 && $urandom_range(0, 7) == 0) ? 1'b0 : 1'b1, g, h);
    endtask

    // directed rows: register write, pixel or drain, with an optional known result
    typedef enum logic [1:0] { ROW_REG, ROW_PIX, ROW_DRAIN } t_row_kind;
    typedef struct {
        t_row_kind   kind;
        t_cfg_idx    idx;
        logic [15:0] val;
        bit          known;
        t_out_word   want;
    } t_row;

    t_row plan [] = '{
        // drain before any frame is dropped
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 0, '0},
        '{ROW_REG, CFG_IMAGE_WIDTH, 16'd2, 0, '0},
        '{ROW_REG, CFG_IMAGE_HEIGHT, 16'd2, 0, '0},
        // flat white 2x2 frame, reset weights sum just over one
        '{ROW_PIX, CFG_IMAGE_WIDTH, 16'd255, 0, '0},
        '{ROW_PIX, CFG_IMAGE_WIDTH, 16'd255, 0, '0},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 0, '0},   // mid-frame drain, ignored
        '{ROW_PIX, CFG_IMAGE_WIDTH, 16'd255, 0, '0},
        '{ROW_PIX, CFG_IMAGE_WIDTH, 16'd255, 0, '0},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 0, '0},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 0, '0},
        '{ROW_PIX, CFG_IMAGE_WIDTH, 16'd0, 1, '{8'd255, 1'b0}},  // pixel acts as drain
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 1, '{8'd255, 1'b0}},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 1, '{8'd255, 1'b0}},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 1, '{8'd255, 1'b1}},
        // all weights zero, everything blurs to black
        '{ROW_REG, CFG_COEF_OUTER, 16'd0, 0, '0},
        '{ROW_REG, CFG_COEF_INNER, 16'd0, 0, '0},
        '{ROW_REG, CFG_COEF_CENTER, 16'd0, 0, '0},
        '{ROW_PIX, CFG_IMAGE_WIDTH, 16'd255, 0, '0},
        '{ROW_PIX, CFG_IMAGE_WIDTH, 16'd128, 0, '0},
        '{ROW_PIX, CFG_IMAGE_WIDTH, 16'd1, 0, '0},
        '{ROW_PIX, CFG_IMAGE_WIDTH, 16'd0, 0, '0},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 0, '0},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 0, '0},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 1, '{8'd0, 1'b0}},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 1, '{8'd0, 1'b0}},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 1, '{8'd0, 1'b0}},
        '{ROW_DRAIN, CFG_IMAGE_WIDTH, 16'd0, 1, '{8'd0, 1'b1}}
    };

    initial begin
        t_out_word g;
        bit h;
        int k;
        // predictor reset state
        foreach (raw_lines[i]) raw_lines[i] = '0;
        foreach (vwin[i]) vwin[i] = '0;
        pos_col = 0; pos_row = 0; lat_w = 0; lat_h = 0; held_pix = '0;
        reg_w = 11'd640; reg_h = 11'd480;
        w_outer = 16'd3572; w_inner = 16'd16004; w_center = 16'd26385;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed walk
        for (int i = 0; i < plan.size(); i++) begin
            if (plan[i].kind == ROW_REG) begin
                if (i == 0 || plan[i-1].kind != ROW_REG) settle();
                write_reg(plan[i].idx, plan[i].val);
                if (i + 1 < plan.size() && plan[i+1].kind != ROW_REG) begin
                    cfg_valid <= 1'b0;
                    @(negedge i_clk);
                end
            end else begin
                send_word(plan[i].val[7:0], plan[i].kind == ROW_DRAIN, g, h);
                if (plan[i].known && (!h || g !== plan[i].want)) begin
                    $error("pixel_out: expected %0d, actual %0d (predicted, row %0d)",
                           plan[i].want.pixel_out, g.pixel_out, i);
                    mismatches++;
                end
            end
        end

        // random frames: small mostly, with a few clamped sizes and extreme weights
        k = 0;
        while (words_sent < 950) begin
            logic [15:0] co, ci, cc;
            k++;
            case ($urandom_range(0, 4))
                0: begin co = 16'hFFFF; ci = 16'hFFFF; cc = 16'hFFFF; end
                1: begin co = 16'd3572; ci = 16'd16004; cc = 16'd26385; end
                default: begin co = 16'($urandom); ci = 16'($urandom); cc = 16'($urandom); end
            endcase
            if (k == 3)
                setup_frame(16'd0, 16'd1, co, ci, cc);         // both clamp low
            else if (k == 5)
                setup_frame(16'd1, 16'd0, co, ci, cc);         // both clamp low
            else if (k == 7)
                setup_frame(16'hF803, 16'hF802, co, ci, cc);   // upper bits dropped
            else
                setup_frame(16'($urandom_range(2, 12)), 16'($urandom_range(2, 8)), co, ci, cc);
            quiet = (words_sent > 800);
            random_frame(k % 3);
        end
        quiet = 1'b1;
        in_valid <= 1'b0;

        while (blurred_q.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("covered %0d frames, %0d words in, %0d blurred pixels out",
                 frames_done, words_sent, pixels_out);
        $display("sizes from the low clamp up to 12x8, masked size writes, zero and full weights");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
